### sv/bts_pkg.sv
// Package for the bicubic texture sampler: sizes, codes, controller types.
// No dependencies.
`default_nettype none
package bts_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int AddrW     = 16;

    localparam logic [1:0] WRAP_CLAMP  = 2'd0;
    localparam logic [1:0] WRAP_REPEAT = 2'd1;
    localparam logic [1:0] WRAP_MIRROR = 2'd2;

    localparam logic [1:0] REG_WRAP   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_WGT   = 6'b000100,
        ST_TAPS  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input transaction
        logic       write;     // store texel
        logic       setup;     // fold and position
        logic [1:0] wstep;     // weight pipeline step
        logic       wgt;
        logic       fetch;     // issue tap read
        logic [3:0] tap;       // tap number for the fetch
        logic       clear;     // clear accumulators
        logic       finish;    // load output register
    } cmd_t;
endpackage
`default_nettype wire

### sv/bts_datapath.sv
// Datapath of the bicubic sampler: texel memory, weights, accumulators.
// Depends on bts_pkg.
`default_nettype none
module bts_datapath import bts_pkg::*; (
    input  wire logic              clk,
    input  wire cmd_t              cmd,
    input  wire logic [1:0]        wrap_mode,
    input  wire logic [8:0]        tex_width,
    input  wire logic [8:0]        tex_height,
    input  wire logic [15:0]       texel_index,
    input  wire logic [15:0]       texel_red,
    input  wire logic [15:0]       texel_green,
    input  wire logic [15:0]       texel_blue,
    input  wire logic [15:0]       texel_alpha,
    input  wire logic signed [31:0] coord_u,
    input  wire logic signed [31:0] coord_v,
    output logic signed [17:0]     out_red,
    output logic signed [17:0]     out_green,
    output logic signed [17:0]     out_blue,
    output logic signed [17:0]     out_alpha
);
    logic [63:0] mem [0:(1<<AddrW)-1];
    logic [63:0] rd_reg;
    logic [15:0] idx_reg;
    logic [63:0] wdat_reg;
    logic signed [31:0] cu_reg, cv_reg;

    // effective sizes
    logic [8:0] wdt, hgt;
    always_comb
    begin
        wdt = (tex_width == 9'd0) ? 9'd1 :
              (tex_width > 9'(MaxWidth)) ? 9'(MaxWidth) : tex_width;
        hgt = (tex_height == 9'd0) ? 9'd1 :
              (tex_height > 9'(MaxHeight)) ? 9'(MaxHeight) : tex_height;
    end

    // fold one coordinate into 0..1.0 Q.16
    function automatic logic [16:0] fold(input logic [31:0] b, input logic [1:0] m);
        logic [16:0] r;
        begin
            if (m == WRAP_REPEAT) r = {1'b0, b[15:0]};
            else if (m == WRAP_MIRROR)
                r = b[16] ? 17'(18'h20000 - {1'b0, b[16:0]}) : {1'b0, b[15:0]};
            else if (b[31]) r = 17'd0;
            else if (b[30:16] != 15'd0) r = 17'h10000;
            else r = {1'b0, b[15:0]};
            fold = r;
        end
    endfunction

    // p = u*size + 0.5 (non-negative); base = p>>16 - 1
    logic [25:0] px_reg, py_reg;
    logic [15:0] tx, ty;
    assign tx = px_reg[15:0];
    assign ty = py_reg[15:0];

    // weights: sequenced products on a shared path per axis
    logic [15:0] t2x_reg, t2y_reg, t3x_reg, t3y_reg;
    logic [31:0] mx, my;
    always_comb
    begin
        mx = (cmd.wstep == 2'd0) ? 32'(tx) * 32'(tx) : 32'(t2x_reg) * 32'(tx);
        my = (cmd.wstep == 2'd0) ? 32'(ty) * 32'(ty) : 32'(t2y_reg) * 32'(ty);
    end

    function automatic logic signed [18:0] wsel(input logic [1:0] i, input logic [15:0] t,
                                                 input logic [15:0] t2, input logic [15:0] t3);
        logic signed [19:0] a, b2, c3;
        begin
            a  = 20'(t);
            b2 = 20'(t2);
            c3 = 20'(t3);
            case (i)
                2'd0:    wsel = 19'(-c3 + 2*b2 - a);
                2'd1:    wsel = 19'(3*c3 - 5*b2 + 20'sh20000);
                2'd2:    wsel = 19'(-3*c3 + 4*b2 + a);
                default: wsel = 19'(c3 - b2);
            endcase
        end
    endfunction

    // tap addressing for one axis
    function automatic logic [8:0] taddr(input logic signed [11:0] x, input logic [8:0] s,
                                         input logic [1:0] m);
        logic signed [11:0] r;
        begin
            if (m == WRAP_REPEAT) begin
                // x lies within -2..s+1: at most two corrections either way (size 1)
                r = x;
                if (r < 0) r = r + 12'(s);
                if (r < 0) r = r + 12'(s);
                if (r >= 12'(s)) r = r - 12'(s);
                if (r >= 12'(s)) r = r - 12'(s);
            end else begin
                r = x;
                if (r < 0) r = 12'sd0;
                else if (r > 12'(s) - 12'sd1) r = 12'(s) - 12'sd1;
            end
            taddr = r[8:0];
        end
    endfunction

    logic signed [11:0] bx, by;
    logic [8:0] ax, ay;
    logic [15:0] raddr;
    assign bx = 12'(px_reg[25:16]) - 12'sd1;
    assign by = 12'(py_reg[25:16]) - 12'sd1;
    assign ax = taddr(bx - 12'sd1 + 12'(cmd.tap[1:0]), wdt, wrap_mode);
    assign ay = taddr(by - 12'sd1 + 12'(cmd.tap[3:2]), hgt, wrap_mode);
    assign raddr = 16'(18'(ay) * 18'(wdt) + 18'(ax));

    // memory, single port
    always_ff @(posedge clk)
    begin
        if (cmd.write) mem[idx_reg] <= wdat_reg;
        else if (cmd.fetch) rd_reg <= mem[raddr];
    end

    // weight product for the fetched tap, registered through tap_d_reg and wprod_reg
    logic [3:0] tap_d_reg;
    logic       vld_d_reg;
    logic signed [37:0] wprod_reg;
    logic signed [37:0] wprod_next;
    logic signed [18:0] wx_sel, wy_sel;
    logic [63:0] rd_d_reg;
    logic        vld_dd_reg;
    assign wx_sel = wsel(tap_d_reg[1:0], tx, t2x_reg, t3x_reg);
    assign wy_sel = wsel(tap_d_reg[3:2], ty, t2y_reg, t3y_reg);
    assign wprod_next = 38'(wx_sel) * 38'(wy_sel);

    logic signed [55:0] acc_reg [0:3];
    logic signed [53:0] prod [0:3];
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            prod[c] = 54'($signed({1'b0, rd_d_reg[16*c +: 16]})) * 54'(wprod_reg);
    end

    function automatic logic signed [17:0] fin(input logic signed [55:0] a);
        logic signed [55:0] v;
        begin
            v = (a + 56'sh200000000) >>> 34;
            if (v < -56'sd32768) fin = -18'sd32768;
            else if (v > 56'sd98303) fin = 18'sd98303;
            else fin = v[17:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg  <= texel_index;
            wdat_reg <= {texel_alpha, texel_blue, texel_green, texel_red};
            cu_reg   <= coord_u;
            cv_reg   <= coord_v;
        end
        if (cmd.setup)
        begin
            px_reg <= 26'(fold(cu_reg, wrap_mode) * 26'(wdt) + 26'h8000);
            py_reg <= 26'(fold(cv_reg, wrap_mode) * 26'(hgt) + 26'h8000);
        end
        if (cmd.wgt)
        begin
            if (cmd.wstep == 2'd0)
            begin
                t2x_reg <= mx[31:16];
                t2y_reg <= my[31:16];
            end
            else
            begin
                t3x_reg <= mx[31:16];
                t3y_reg <= my[31:16];
            end
        end
        tap_d_reg  <= cmd.tap;
        vld_d_reg  <= cmd.fetch;
        wprod_reg  <= wprod_next;
        rd_d_reg   <= rd_reg;
        vld_dd_reg <= vld_d_reg;
        for (int c = 0; c < 4; c++)
        begin
            if (cmd.clear) acc_reg[c] <= '0;
            else if (vld_dd_reg) acc_reg[c] <= acc_reg[c] + 56'(prod[c]);
        end
        if (cmd.finish)
        begin
            out_red   <= fin(acc_reg[0]);
            out_green <= fin(acc_reg[1]);
            out_blue  <= fin(acc_reg[2]);
            out_alpha <= fin(acc_reg[3]);
        end
    end
endmodule
`default_nettype wire

### sv/bts_ctrl.sv
// Controller of the bicubic sampler: sequences load, write, setup, weights, taps, drain, output.
// Depends on bts_pkg.
`default_nettype none
module bts_ctrl import bts_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic command,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);
    state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       wr_reg, wr_next;
    logic       ov_reg, ov_next;

    assign in_ready  = (state_reg == ST_IDLE) && !wr_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        wr_next    = 1'b0;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.write  = wr_reg;
        cmd.tap    = cnt_reg;
        cmd.wstep  = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    if (command == CMD_SAMPLE) state_next = ST_SETUP;
                    else wr_next = 1'b1;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                cmd.clear  = 1'b1;
                cnt_next   = '0;
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                cmd.wgt  = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    cnt_next   = '0;
                    state_next = ST_TAPS;
                end
            end
            ST_TAPS:
            begin
                cmd.fetch = 1'b1;
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3) state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            wr_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wr_reg    <= wr_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

### sv/bicubic_texture_sampler_core.sv
// Bicubic texture sampler top level: config registers, controller, datapath.
// A texel write is captured into a register, then stored. A sample runs setup,
// two weight steps, 16 tap reads from the single-port texel memory, drain, output.
// Input is taken again once the sample is back in idle; a waiting result delays that.
// Reset clears control and config; texel memory contents are undefined.
`default_nettype none
module bicubic_texture_sampler_core import bts_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              command,
    input  wire logic [15:0]       texel_index,
    input  wire logic [15:0]       texel_red,
    input  wire logic [15:0]       texel_green,
    input  wire logic [15:0]       texel_blue,
    input  wire logic [15:0]       texel_alpha,
    input  wire logic signed [31:0] coord_u,
    input  wire logic signed [31:0] coord_v,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [17:0]     out_red,
    output logic signed [17:0]     out_green,
    output logic signed [17:0]     out_blue,
    output logic signed [17:0]     out_alpha,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [8:0]        cfg_data
);
    logic [1:0] wrap_reg;
    logic [8:0] width_reg, height_reg;
    cmd_t cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg   <= WRAP_CLAMP;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WRAP:   wrap_reg   <= cfg_data[1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    bts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
    );

    bts_datapath u_dp (
        .clk(clk), .cmd(cmd), .wrap_mode(wrap_reg), .tex_width(width_reg),
        .tex_height(height_reg), .texel_index(texel_index), .texel_red(texel_red),
        .texel_green(texel_green), .texel_blue(texel_blue), .texel_alpha(texel_alpha),
        .coord_u(coord_u), .coord_v(coord_v), .out_red(out_red),
        .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha)
    );
endmodule
`default_nettype wire

### sv/bts_checker.sv
// Port-level checker for the bicubic sampler, bound to the top level.
// Depends on bts_pkg only through the bound module.
`default_nettype none
module bts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        command,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [17:0] out_red
);
    // a result that waits holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red))
        else $error("stalled result changed");
    // a texel write never produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !command && !out_valid |=> !out_valid)
        else $error("result after write");
    // a sample blocks input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command |=> !in_ready)
        else $error("input taken during sample");
    // no result out of reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind bicubic_texture_sampler_core bts_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red)
);
`default_nettype wire

### bench/bicubic_texture_sampler_core_test.sv
// Testbench for bicubic_texture_sampler_core: fills the texel store, then drives
// texel writes and bicubic samples under several wrap modes and sizes.
// Depends on bts_pkg and the core; expected colors come from a local filter model.
`default_nettype none
module bicubic_texture_sampler_core_test;
    import bts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [17:0] red;
        logic signed [17:0] green;
        logic signed [17:0] blue;
        logic signed [17:0] alpha;
    } rgba_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [15:0]        texel_index;
    logic [15:0]        texel_red;
    logic [15:0]        texel_green;
    logic [15:0]        texel_blue;
    logic [15:0]        texel_alpha;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
    logic               out_valid;
    logic               out_ready;
    logic signed [17:0] out_red;
    logic signed [17:0] out_green;
    logic signed [17:0] out_blue;
    logic signed [17:0] out_alpha;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [8:0]         cfg_data;

    // local copy of the block state
    logic [63:0] texels [65536];
    bit          texel_known [65536];
    logic [1:0]  cur_wrap;
    logic [8:0]  cur_width;
    logic [8:0]  cur_height;

    rgba_t expected_colors [$];
    int    fail_count;
    int    burst_left;

    bicubic_texture_sampler_core dut (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ---------------- filter model ----------------
    function automatic longint eff_size(logic [8:0] r, int mx);
        if (r == 0) return 1;
        if (r > mx) return longint'(mx);
        return longint'(r);
    endfunction

    function automatic longint fold_axis(logic [31:0] raw);
        longint s;
        longint m;
        s = longint'(signed'(raw));
        if (cur_wrap == WRAP_REPEAT) return longint'(raw[15:0]);
        if (cur_wrap == WRAP_MIRROR)
        begin
            m = longint'(raw[16:0]);
            return (m < 65536) ? m : 131072 - m;
        end
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        return s;
    endfunction

    function automatic longint axis_weights(longint u, longint size, output longint w[4]);
        longint p, t, t2, t3;
        p  = u * size - 32768 + 65536;
        t  = p & 64'hFFFF;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        w[0] = -t3 + 2 * t2 - t;
        w[1] = 3 * t3 - 5 * t2 + 2 * 65536;
        w[2] = -3 * t3 + 4 * t2 + t;
        w[3] = t3 - t2;
        return (p >> 16) - 1;
    endfunction

    function automatic longint tap_addr(longint x, longint size);
        longint r;
        if (cur_wrap == WRAP_REPEAT)
        begin
            r = x % size;
            if (r < 0) r += size;
            return r;
        end
        if (x < 0) return 0;
        if (x > size - 1) return size - 1;
        return x;
    endfunction

    function automatic logic signed [17:0] round_sat(longint acc);
        longint v;
        v = (acc + (64'sd1 <<< 33)) >>> 34;
        if (v < -32768) v = -32768;
        if (v > 98303) v = 98303;
        return v[17:0];
    endfunction

    function automatic rgba_t filter_texels(logic [31:0] u, logic [31:0] v);
        longint wdt, hgt, bx, by, x, y, weight, ch;
        longint wx[4], wy[4], acc[4];
        logic [63:0] tx;
        rgba_t res;
        wdt = eff_size(cur_width, MaxWidth);
        hgt = eff_size(cur_height, MaxHeight);
        bx = axis_weights(fold_axis(u), wdt, wx);
        by = axis_weights(fold_axis(v), hgt, wy);
        for (int c = 0; c < 4; c++) acc[c] = 0;
        for (int j = 0; j < 4; j++)
        begin
            y = tap_addr(by - 1 + j, hgt);
            for (int i = 0; i < 4; i++)
            begin
                x = tap_addr(bx - 1 + i, wdt);
                tx = texels[(y * wdt + x) & 64'hFFFF];
                weight = wx[i] * wy[j];
                for (int c = 0; c < 4; c++)
                begin
                    ch = longint'(tx[16*c +: 16]);
                    acc[c] += ch * weight;
                end
            end
        end
        res.red   = round_sat(acc[0]);
        res.green = round_sat(acc[1]);
        res.blue  = round_sat(acc[2]);
        res.alpha = round_sat(acc[3]);
        return res;
    endfunction

    // ---------------- sender ----------------
    task automatic send_item(input logic cmd, input logic [15:0] idx,
                             input logic [63:0] rgba, input logic [31:0] u,
                             input logic [31:0] v);
        in_valid    <= 1'b1;
        command     <= cmd;
        texel_index <= idx;
        texel_red   <= rgba[15:0];
        texel_green <= rgba[31:16];
        texel_blue  <= rgba[47:32];
        texel_alpha <= rgba[63:48];
        coord_u     <= u;
        coord_v     <= v;
        do @(posedge clk); while (!in_ready);
        if (cmd == CMD_SAMPLE)
            expected_colors.insert(expected_colors.size(), filter_texels(u, v));
        else
        begin
            texels[idx] = rgba;
            texel_known[idx] = 1'b1;
        end
        // bursts with random gaps
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = $urandom_range(1, 14);
        end
    endtask

    task automatic write_texel(input logic [15:0] idx, input logic [63:0] rgba);
        send_item(CMD_WRITE, idx, rgba, $urandom, $urandom);
    endtask

    task automatic sample_at(input logic [31:0] u, input logic [31:0] v);
        send_item(CMD_SAMPLE, 16'($urandom), {$urandom, $urandom}, u, v);
    endtask

    // wait until the block is idle, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WRAP:   cur_wrap = val[1:0];
            REG_WIDTH:  cur_width = val;
            REG_HEIGHT: cur_height = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic [1:0] wrap, input logic [8:0] w, input logic [8:0] h);
        write_reg(REG_WRAP, 9'(wrap));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // every tap lands inside width*height, so write whatever is missing there
    task automatic fill_area();
        int n;
        n = int'(eff_size(cur_width, MaxWidth) * eff_size(cur_height, MaxHeight));
        for (int i = 0; i < n; i++)
            if (!texel_known[i]) write_texel(16'(i), {$urandom, $urandom});
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h0001_0000 * $urandom_range(0, 4) - 32'h0002_0000;
            2:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'(0)} | $urandom_range(0, 3);
            default: return 32'($urandom_range(0, 393216)) - 32'd196608;
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        set_mode(WRAP_CLAMP, 4, 4);
        for (int i = 0; i < 16; i++)
            write_texel(16'(i), (i % 3 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                (i % 3 == 1) ? 64'h0 : {$urandom, $urandom});
        // write outside the used area
        write_texel(16'hFFFF, 64'h1234_5678_9ABC_DEF0);
        sample_at(32'h0, 32'h0);
        sample_at(32'h0001_0000, 32'h0001_0000);
        sample_at(32'h0000_8000, 32'h0000_4000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'h7FFF_FFFF, 32'h8000_0000);
        sample_at(32'hFFFF_FFFF, 32'h0000_FFFF);
        write_reg(REG_WRAP, 9'(WRAP_REPEAT));
        sample_at(32'hFFFF_C000, 32'h0003_2000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        write_reg(REG_WRAP, 9'(WRAP_MIRROR));
        sample_at(32'h0001_8000, 32'hFFFF_C000);
        sample_at(32'h0001_0000, 32'h0002_0000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        // unused wrap code behaves as clamp
        write_reg(REG_WRAP, 9'd3);
        sample_at(32'hFFFF_0000, 32'h0002_0000);
        sample_at(32'h0000_8000, 32'h0000_8000);
    endtask

    task automatic test_random_phase(input logic [1:0] wrap, input logic [8:0] w,
                                     input logic [8:0] h, input int count);
        set_mode(wrap, w, h);
        fill_area();
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 3) == 0)
                write_texel(16'($urandom), {$urandom, $urandom});
            else
                sample_at(random_coord(), random_coord());
        // refill whatever the random writes left untouched stays valid; nothing to do
    endtask

    task automatic test_random();
        test_random_phase(WRAP_REPEAT, 5, 3, 110);
        test_random_phase(WRAP_MIRROR, 1, 1, 90);
        test_random_phase(WRAP_CLAMP, 256, 1, 100);
        test_random_phase(WRAP_REPEAT, 1, 256, 100);
        test_random_phase(2'd3, 0, 0, 80);
        test_random_phase(WRAP_MIRROR, 511, 2, 100);
        test_random_phase(WRAP_CLAMP, 7, 9, 110);
        test_random_phase(WRAP_REPEAT, 16, 16, 120);
        test_random_phase(WRAP_MIRROR, 3, 11, 110);
    endtask

    // ---------------- receiver and checker ----------------
    int stall_cnt;
    int stall_style;
    always @(posedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 97 == 0) stall_style <= $urandom_range(0, 2);
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        rgba_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_colors.size() == 0)
            begin
                $display("%0t: unexpected result %0d %0d %0d %0d", $time,
                         out_red, out_green, out_blue, out_alpha);
                fail_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (out_red !== want.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time, want.red, out_red);
                    fail_count++;
                end
                if (out_green !== want.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time, want.green, out_green);
                    fail_count++;
                end
                if (out_blue !== want.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue, out_blue);
                    fail_count++;
                end
                if (out_alpha !== want.alpha)
                begin
                    $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, out_alpha);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_WRITE;
        texel_index = '0;
        texel_red = '0;
        texel_green = '0;
        texel_blue = '0;
        texel_alpha = '0;
        coord_u = '0;
        coord_v = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WRAP;
        cfg_data = '0;
        stall_cnt = 0;
        stall_style = 0;
        fail_count = 0;
        burst_left = 5;
        cur_wrap = WRAP_CLAMP;
        cur_width = 9'd256;
        cur_height = 9'd256;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();

        in_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #4ms;
        $display("%0t: timeout", $time);
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
